### design/rtwrm_pkg.sv
`default_nettype none
package rtwrm_pkg;
	localparam logic [1:0] CMD_ADD      = 2'd0;
	localparam logic [1:0] CMD_ATTEMPT  = 2'd1;
	localparam logic [1:0] CMD_RESPONSE = 2'd2;
	localparam logic [1:0] CMD_SELECT   = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] client_tag;
		logic [7:0]  air_command;
		logic [7:0]  air_address;
		logic        air_is_response;
		logic [31:0] air_data;
		logic [3:0]  slot;
		logic        sent_ok;
		logic [31:0] now;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  slot_out;
		logic [31:0] packet_number;
		logic [15:0] client_out;
		logic [7:0]  command_out;
		logic [7:0]  address_out;
		logic [31:0] data_out;
		logic [7:0]  attempts_out;
	} rsp_t;

	// One table row as stored in the RAM.
	typedef struct packed {
		logic [15:0] client;
		logic [31:0] number;
		logic [7:0]  command;
		logic [7:0]  address;
		logic        response_flag;
		logic [31:0] data;
		logic        shipped;
		logic [7:0]  attempts;
		logic [31:0] time_received;
		logic [31:0] time_sent;
		logic [31:0] time_answered;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);
endpackage
`default_nettype wire

### design/rtwrm_if.sv
`default_nettype none
interface rtwrm_req_if;
	logic valid;
	logic ready;
	rtwrm_pkg::req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface rtwrm_rsp_if;
	logic valid;
	logic ready;
	rtwrm_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### design/request_table_with_response_merge_unit.sv
// Request table with response merge.
// Commands arrive as words on the req channel (valid/ready); each produces
// exactly one result word on the rsp channel. The block works on one command
// at a time: ready is high only while idle and no result word is waiting.
// Add and attempt pass through S_SCAN to S_OUT; select, and a response that
// finds nothing, walk the table once (S_EVAL, S_DONE, S_OUT); a response that
// finds its entry walks it twice, a match pass then a merge pass (S_MERGE),
// over the N entries in use (at most ENTRIES). The next command can be
// accepted once the result word is taken and the sequencer is back in idle.
// The rows live in one RAM with a registered read port; a sequencer walks it
// one row per cycle, and a single compare unit evaluates each row as it comes out.
// The result sits in an output register until taken; while the receiver
// stalls no new command is accepted. Reset empties the table (count and
// packet number go to zero) and no clearing pass is needed, since only rows
// below the count are ever read.
`default_nettype none
module request_table_with_response_merge_unit #(
	parameter int ENTRIES = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rtwrm_req_if.sink  req,
	rtwrm_rsp_if.source rsp
);
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_EVAL  = 3'd2;
	localparam logic [2:0] S_MERGE = 3'd3;
	localparam logic [2:0] S_FETCH = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]          state_q;
	logic [CW-1:0]       count_q;
	logic [31:0]         last_q;
	rtwrm_pkg::req_t     cmd_q;
	logic [CW-1:0]       idx_q;     // next row to read
	logic [CW-1:0]       cur_q;     // row whose data is on rdata
	logic                rd_vld_q;
	logic                have_q;
	logic [AW-1:0]       best_q;
	rtwrm_pkg::entry_t   best_e_q;
	rtwrm_pkg::rsp_t     out_q;
	logic                out_vld_q;

	logic                we;
	logic [AW-1:0]       waddr, raddr;
	rtwrm_pkg::entry_t   wdata, rdata;

	rtwrm_ram #(.WIDTH(rtwrm_pkg::ENTRY_W), .DEPTH(ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign req.ready = (state_q == S_IDLE) && !out_vld_q;
	assign rsp.valid = out_vld_q;
	assign rsp.payload = out_q;

	logic is_match, cand, better;
	assign is_match = !rdata.response_flag && rdata.command == cmd_q.air_command
		&& rdata.address == cmd_q.air_address;
	assign cand = !rdata.response_flag && !rdata.shipped;
	assign better = rdata.time_received < best_e_q.time_received
		&& rdata.attempts >= best_e_q.attempts
		&& rdata.time_sent <= best_e_q.time_sent;

	assign raddr = (state_q == S_IDLE) ? AW'(req.payload.slot) : idx_q[AW-1:0];

	rtwrm_pkg::entry_t new_e, att_e, ans_e, cp_e;
	always_comb begin
		new_e = '0;
		new_e.client = cmd_q.client_tag;
		new_e.number = last_q + 32'd1;
		new_e.command = cmd_q.air_command;
		new_e.address = cmd_q.air_address;
		new_e.response_flag = cmd_q.air_is_response;
		new_e.data = cmd_q.air_data;
		new_e.time_received = cmd_q.now;

		att_e = rdata;
		att_e.time_sent = cmd_q.now;
		if (rdata.attempts != 8'hFF) begin
			att_e.attempts = rdata.attempts + 8'd1;
		end
		if (cmd_q.sent_ok) begin
			att_e.shipped = 1'b1;
		end

		ans_e = rdata;
		ans_e.response_flag = cmd_q.air_is_response;
		ans_e.data = cmd_q.air_data;
		ans_e.time_answered = cmd_q.now;

		cp_e = rdata;
		cp_e.response_flag = best_e_q.response_flag;
		cp_e.data = best_e_q.data;
		cp_e.time_sent = best_e_q.time_sent;
		cp_e.time_answered = best_e_q.time_answered;
		cp_e.shipped = best_e_q.shipped;
		cp_e.attempts = best_e_q.attempts;
	end

	always_comb begin
		we = 1'b0;
		waddr = cur_q[AW-1:0];
		wdata = rdata;
		case (state_q)
			S_SCAN: begin
				if (cmd_q.command == rtwrm_pkg::CMD_ADD) begin
					we = count_q != CW'(ENTRIES);
					waddr = count_q[AW-1:0];
					wdata = new_e;
				end else if (cmd_q.command == rtwrm_pkg::CMD_ATTEMPT) begin
					we = rd_vld_q;
					wdata = att_e;
				end
			end
			S_EVAL: begin
				if (rd_vld_q && cmd_q.command == rtwrm_pkg::CMD_RESPONSE && !have_q
						&& is_match && rdata.time_sent != 32'd0) begin
					we = 1'b1;
					wdata = ans_e;
				end
			end
			S_MERGE: begin
				if (rd_vld_q && is_match && rdata.time_sent == 32'd0) begin
					we = 1'b1;
					wdata = cp_e;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			last_q <= '0;
			out_vld_q <= 1'b0;
			idx_q <= '0;
			cur_q <= '0;
			rd_vld_q <= 1'b0;
			have_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						cmd_q <= req.payload;
						have_q <= 1'b0;
						out_q <= '0;
						cur_q <= CW'(req.payload.slot);
						rd_vld_q <= 32'(req.payload.slot) < 32'(count_q);
						idx_q <= '0;
						state_q <= S_SCAN;
						if (req.payload.command == rtwrm_pkg::CMD_RESPONSE
								|| req.payload.command == rtwrm_pkg::CMD_SELECT) begin
							state_q <= S_EVAL;
							rd_vld_q <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					// Add and attempt finish here.
					state_q <= S_OUT;
					if (cmd_q.command == rtwrm_pkg::CMD_ADD) begin
						if (count_q == CW'(ENTRIES)) begin
							out_q.status <= rtwrm_pkg::ST_FULL;
						end else begin
							last_q <= last_q + 32'd1;
							count_q <= count_q + CW'(1);
							out_q.slot_out <= 4'(count_q);
							out_q.packet_number <= last_q + 32'd1;
						end
					end else if (!rd_vld_q) begin
						out_q.status <= rtwrm_pkg::ST_NONE;
					end else begin
						out_q.slot_out <= cmd_q.slot;
						out_q.packet_number <= rdata.number;
					end
				end
				S_EVAL: begin
					// rdata holds row cur_q when rd_vld_q.
					if (rd_vld_q) begin
						if (cmd_q.command == rtwrm_pkg::CMD_RESPONSE) begin
							if (!have_q && is_match && rdata.time_sent != 32'd0) begin
								have_q <= 1'b1;
								best_q <= cur_q[AW-1:0];
								best_e_q <= ans_e;
							end
						end else if (cand && (!have_q || better)) begin
							have_q <= 1'b1;
							best_q <= cur_q[AW-1:0];
							best_e_q <= rdata;
						end
					end
					cur_q <= idx_q;
					rd_vld_q <= idx_q < count_q;
					idx_q <= idx_q + CW'(1);
					if (rd_vld_q ? (cur_q + CW'(1) >= count_q) : (count_q == '0)) begin
						state_q <= S_DONE;
						rd_vld_q <= 1'b0;
					end
				end
				S_DONE: begin
					idx_q <= CW'(1);
					cur_q <= '0;
					rd_vld_q <= count_q != '0;
					if (!have_q) begin
						out_q.status <= rtwrm_pkg::ST_NONE;
						state_q <= S_OUT;
					end else if (cmd_q.command == rtwrm_pkg::CMD_RESPONSE) begin
						state_q <= S_MERGE;
						idx_q <= '0;
						rd_vld_q <= 1'b0;
						out_q.slot_out <= 4'(best_q);
						out_q.packet_number <= best_e_q.number;
					end else begin
						state_q <= S_OUT;
						out_q.slot_out <= 4'(best_q);
						out_q.packet_number <= best_e_q.number;
						out_q.client_out <= best_e_q.client;
						out_q.command_out <= best_e_q.command;
						out_q.address_out <= best_e_q.address;
						out_q.data_out <= best_e_q.data;
						out_q.attempts_out <= best_e_q.attempts;
					end
				end
				S_MERGE: begin
					// idx_q is the row being addressed; cur_q lags by one.
					cur_q <= idx_q;
					rd_vld_q <= idx_q < count_q;
					idx_q <= idx_q + CW'(1);
					if (rd_vld_q && cur_q + CW'(1) >= count_q) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					out_vld_q <= 1'b1;
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Rows above the count are never written.
	assert property (@(posedge clk) disable iff (!arst_n)
		we |-> CW'(waddr) <= count_q)
		else $error("write beyond table fill");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES))
		else $error("count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("ready while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.payload))
		else $error("result dropped");
endmodule
`default_nettype wire

### design/rtwrm_ram.sv
`default_nettype none
module rtwrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### bench/request_table_checker.sv
`timescale 1ns / 1ps
module request_table_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	input  wire logic req_ready,
	input  rtwrm_pkg::req_t req_word,
	input  wire logic rsp_valid,
	input  wire logic rsp_ready,
	input  rtwrm_pkg::rsp_t rsp_word,
	output int errors,
	output int pending,
	output int answers_matched,
	output int selects_found
);
	localparam int N = 16;

	rtwrm_pkg::entry_t rows [N];
	int unsigned row_count;
	logic [31:0] next_number;
	rtwrm_pkg::rsp_t expected_q [$];

	function automatic logic row_matches(int i, logic [7:0] c, logic [7:0] a);
		return !rows[i].response_flag && rows[i].command == c && rows[i].address == a;
	endfunction

	task automatic apply_command(input rtwrm_pkg::req_t r);
		rtwrm_pkg::rsp_t o;
		int f;
		int c;
		logic have;
		o = '0;
		case (r.command)
			rtwrm_pkg::CMD_ADD: begin
				if (row_count >= N) begin
					o.status = rtwrm_pkg::ST_FULL;
				end else begin
					next_number = next_number + 1;
					rows[row_count] = '0;
					rows[row_count].client = r.client_tag;
					rows[row_count].number = next_number;
					rows[row_count].command = r.air_command;
					rows[row_count].address = r.air_address;
					rows[row_count].response_flag = r.air_is_response;
					rows[row_count].data = r.air_data;
					rows[row_count].time_received = r.now;
					o.slot_out = row_count[3:0];
					o.packet_number = next_number;
					row_count++;
				end
			end
			rtwrm_pkg::CMD_ATTEMPT: begin
				if (r.slot >= row_count) begin
					o.status = rtwrm_pkg::ST_NONE;
				end else begin
					rows[r.slot].time_sent = r.now;
					if (rows[r.slot].attempts != 8'hff)
						rows[r.slot].attempts++;
					if (r.sent_ok)
						rows[r.slot].shipped = 1'b1;
					o.slot_out = r.slot;
					o.packet_number = rows[r.slot].number;
				end
			end
			rtwrm_pkg::CMD_RESPONSE: begin
				f = -1;
				for (int i = 0; i < row_count; i++)
					if (f < 0 && row_matches(i, r.air_command, r.air_address) &&
					    rows[i].time_sent != 0)
						f = i;
				if (f < 0) begin
					o.status = rtwrm_pkg::ST_NONE;
				end else begin
					answers_matched++;
					rows[f].command = r.air_command;
					rows[f].address = r.air_address;
					rows[f].response_flag = r.air_is_response;
					rows[f].data = r.air_data;
					rows[f].time_answered = r.now;
					for (int i = 0; i < row_count; i++)
						if (row_matches(i, r.air_command, r.air_address) &&
						    rows[i].time_sent == 0) begin
							rows[i].command = rows[f].command;
							rows[i].address = rows[f].address;
							rows[i].response_flag = rows[f].response_flag;
							rows[i].data = rows[f].data;
							rows[i].time_sent = rows[f].time_sent;
							rows[i].time_answered = rows[f].time_answered;
							rows[i].shipped = rows[f].shipped;
							rows[i].attempts = rows[f].attempts;
						end
					o.slot_out = f[3:0];
					o.packet_number = rows[f].number;
				end
			end
			default: begin
				have = 1'b0;
				c = 0;
				for (int i = 0; i < row_count; i++) begin
					if (!rows[i].response_flag && !rows[i].shipped) begin
						if (!have) begin
							have = 1'b1;
							c = i;
						end else if (rows[i].time_received < rows[c].time_received &&
						             rows[i].attempts >= rows[c].attempts &&
						             rows[i].time_sent <= rows[c].time_sent) begin
							c = i;
						end
					end
				end
				if (!have) begin
					o.status = rtwrm_pkg::ST_NONE;
				end else begin
					selects_found++;
					o.slot_out = c[3:0];
					o.packet_number = rows[c].number;
					o.client_out = rows[c].client;
					o.command_out = rows[c].command;
					o.address_out = rows[c].address;
					o.data_out = rows[c].data;
					o.attempts_out = rows[c].attempts;
				end
			end
		endcase
		expected_q.insert(expected_q.size(), o);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count = 0;
			next_number = '0;
			errors = 0;
			answers_matched = 0;
			selects_found = 0;
			expected_q.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result word %h", $time, rsp_word);
					errors++;
				end else begin
					if (expected_q[0] !== rsp_word) begin
						$display("%0t: mismatch expected %h actual %h", $time,
						         expected_q[0], rsp_word);
						errors++;
					end
					void'(expected_q.pop_front());
				end
			end
			// The block accepts a word only while idle, so the result for it
			// can never come in this same edge.
			if (req_valid && req_ready)
				apply_command(req_word);
		end
	end

	assign pending = expected_q.size();
endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors, pending, answers_matched, selects_found;
	int sent_words = 0;
	int stall_left = 0;
	logic calm = 1'b0;

	rtwrm_req_if req ();
	rtwrm_rsp_if rsp ();

	always #2 clk = ~clk;

	request_table_with_response_merge_unit u_top (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	request_table_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req.valid), .req_ready(req.ready), .req_word(req.payload),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_word(rsp.payload),
		.errors(errors), .pending(pending),
		.answers_matched(answers_matched), .selects_found(selects_found)
	);

	// A small pool of command/address pairs makes responses find matches.
	function automatic rtwrm_pkg::req_t make_word(int mode);
		rtwrm_pkg::req_t w;
		w.command = 2'($urandom_range(0, 3));
		w.client_tag = 16'($urandom);
		w.air_data = $urandom;
		w.slot = 4'($urandom);
		w.sent_ok = 1'($urandom_range(0, 3) == 0);
		w.now = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, 1)) : $urandom;
		w.air_is_response = 1'($urandom_range(0, 5) == 0);
		if (mode == 0) begin
			w.air_command = 8'($urandom_range(0, 2));
			w.air_address = 8'($urandom_range(0, 1));
		end else begin
			w.air_command = 8'($urandom);
			w.air_address = 8'($urandom);
		end
		return w;
	endfunction

	// Valid stays high from one word to the next unless an idle gap is taken.
	task automatic send_word(input rtwrm_pkg::req_t w);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.payload <= w;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sent_words++;
	endtask

	task automatic send_fields(input logic [1:0] c, input logic [7:0] ac,
	                           input logic [7:0] aa, input logic resp_flag,
	                           input logic [3:0] s, input logic ok,
	                           input logic [31:0] t);
		rtwrm_pkg::req_t w;
		w = make_word(1);
		w.command = c;
		w.air_command = ac;
		w.air_address = aa;
		w.air_is_response = resp_flag;
		w.slot = s;
		w.sent_ok = ok;
		w.now = t;
		send_word(w);
	endtask

	task automatic wait_drained();
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (calm) begin
			rsp.ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp.ready <= (stall_left == 1);
		end else if ($urandom_range(0, 7) == 0) begin
			rsp.ready <= 1'b0;
			stall_left <= $urandom_range(1, 11);
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	initial begin
		req.valid = 1'b0;
		req.payload = '0;
		rsp.ready = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Empty table: select and response find nothing, attempt has bad slot.
		send_fields(rtwrm_pkg::CMD_SELECT, 8'h00, 8'h00, 1'b0, 4'd0, 1'b0, 32'd5);
		send_fields(rtwrm_pkg::CMD_RESPONSE, 8'h00, 8'h00, 1'b0, 4'd0, 1'b0, 32'd5);
		send_fields(rtwrm_pkg::CMD_ATTEMPT, 8'h00, 8'h00, 1'b0, 4'd15, 1'b1, 32'd5);
		send_fields(rtwrm_pkg::CMD_ADD, 8'hff, 8'hff, 1'b0, 4'd0, 1'b0, 32'hffffffff);
		send_fields(rtwrm_pkg::CMD_ADD, 8'hff, 8'hff, 1'b0, 4'd0, 1'b0, 32'd0);
		send_fields(rtwrm_pkg::CMD_ADD, 8'h00, 8'h00, 1'b1, 4'd0, 1'b0, 32'd3);
		// An attempt at time zero leaves the entry unsent.
		send_fields(rtwrm_pkg::CMD_ATTEMPT, 8'h00, 8'h00, 1'b0, 4'd1, 1'b0, 32'd0);
		send_fields(rtwrm_pkg::CMD_RESPONSE, 8'hff, 8'hff, 1'b0, 4'd0, 1'b0, 32'd9);
		send_fields(rtwrm_pkg::CMD_ATTEMPT, 8'h00, 8'h00, 1'b0, 4'd0, 1'b0, 32'd7);
		send_fields(rtwrm_pkg::CMD_SELECT, 8'h00, 8'h00, 1'b0, 4'd0, 1'b0, 32'd8);
		// Answer merges into the unsent twin in slot one.
		send_fields(rtwrm_pkg::CMD_RESPONSE, 8'hff, 8'hff, 1'b1, 4'd0, 1'b0,
		            32'hffffffff);
		send_fields(rtwrm_pkg::CMD_SELECT, 8'h00, 8'h00, 1'b0, 4'd0, 1'b0, 32'd8);
		send_fields(rtwrm_pkg::CMD_ATTEMPT, 8'h00, 8'h00, 1'b0, 4'd3, 1'b1, 32'd1);
		// Saturate the attempt counter on slot zero.
		repeat (260)
			send_fields(rtwrm_pkg::CMD_ATTEMPT, 8'h00, 8'h00, 1'b0, 4'd0, 1'b0, 32'd2);
		while (sent_words < 900) begin
			rtwrm_pkg::req_t w;
			w = make_word($urandom_range(0, 3) == 0 ? 1 : 0);
			if (w.command == rtwrm_pkg::CMD_ATTEMPT)
				w.slot = 4'($urandom_range(0, 16) % 16);
			if (sent_words > 800)
				calm = 1'b1;
			send_word(w);
		end
		req.valid <= 1'b0;
		wait_drained();
		$display("Covered %0d words: %0d answered responses, %0d found selects.",
		         sent_words, answers_matched, selects_found);
		$display("Table filled to capacity; attempts saturated; empty cases tried.");
		if (errors == 0)
			$display("request_table_with_response_merge_unit test passed");
		else
			$display("request_table_with_response_merge_unit test failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("request_table_with_response_merge_unit test failed");
		$finish;
	end
endmodule
